[design/abbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor bus decoder package
// Shared access codes, reset values and types for the supervisor bus decoder.
// ----------------------------------------------------------------------------
package abbd_pkg;

  localparam logic [1:0] MODE_MEM_RD = 2'd0;
  localparam logic [1:0] MODE_MEM_WR = 2'd1;
  localparam logic [1:0] MODE_IO_RD  = 2'd2;
  localparam logic [1:0] MODE_IO_WR  = 2'd3;

  localparam logic [1:0] ROM_NONE  = 2'd0;
  localparam logic [1:0] ROM_BIOS  = 2'd1;
  localparam logic [1:0] ROM_INSTR = 2'd2;

  localparam logic [1:0] CFG_DIP      = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd2;

  localparam logic [1:0] IO_PORT_NMI      = 2'd0;
  localparam logic [1:0] IO_PORT_DIP_LOW  = 2'd1;
  localparam logic [1:0] IO_PORT_DIP_HIGH = 2'd2;

  localparam logic [4:0] IO_SAVE_BANK = 5'd15;
  localparam logic [4:0] IO_CTRL_HI_BASE = 5'd1;
  localparam logic [4:0] IO_CHAN_BASE = 5'd11;

  localparam logic [9:0] CTRL_RESET = 10'h37f;
  localparam logic [7:0] PROM_IDLE_BITS = 8'he7;
  localparam logic [7:0] PROM_DATA_BIT = 8'h08;
  localparam logic [7:0] PROM_TEST_LIMIT = 8'h40;

  localparam int RAM_AW = 11;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  typedef struct packed {
    logic [63:0] key_low;
    logic [7:0]  key_high;
  } abbd_key_t;

  typedef enum logic [1:0] {
    SRC_LOGIC = 2'd0,
    SRC_WRAM  = 2'd1,
    SRC_SRAM  = 2'd2
  } abbd_src_t;

endpackage

[design/abbd_prom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key PROM serial port
// Holds the bit counter, clock level and test mode of the serial key PROM and
// forms the byte returned by a read of the PROM port.
// ----------------------------------------------------------------------------
module abbd_prom (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [7:0]        wr_data,
  input  abbd_pkg::abbd_key_t key,
  output logic [7:0]        rd_data
);
  import abbd_pkg::*;

  logic       test_mode_r;
  logic       clk_level_r;
  logic [7:0] counter_r;
  logic [7:0] counter_nxt;
  logic       key_bit;
  logic [7:0] data_part;

  always_comb begin
    counter_nxt = counter_r;
    if (clk_level_r && !wr_data[3]) begin
      counter_nxt = counter_r + 8'd1;
    end
    if (!wr_data[0]) begin
      counter_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_mode_r <= 1'b0;
      clk_level_r <= 1'b0;
      counter_r   <= '0;
    end else if (wr_en) begin
      test_mode_r <= wr_data[4];
      clk_level_r <= wr_data[3];
      counter_r   <= counter_nxt;
    end
  end

  always_comb begin
    key_bit = 1'b0;
    if (counter_r[7:6] == 2'b00) begin
      key_bit = key.key_low[counter_r[5:0]];
    end else if (counter_r[7:3] == 5'd8) begin
      key_bit = key.key_high[counter_r[2:0]];
    end
    if (!test_mode_r || counter_r < PROM_TEST_LIMIT) begin
      data_part = {4'b0, ~key_bit, 3'b0};
    end else begin
      data_part = (counter_r[1] ? 8'h00 : key.key_high) ^ PROM_DATA_BIT;
    end
    rd_data = PROM_IDLE_BITS | data_part | {3'b0, ~counter_r[5], 4'b0};
  end

endmodule

[design/arcade_board_bus_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arcade board supervisor bus decoder
// Decodes the supervisor processor memory and I/O map, holds work and save
// RAM, the control and channel latches and the key PROM port.
// ----------------------------------------------------------------------------
// Each bus access passes through the stage-1 register, which holds the
// synchronous RAM read data, and then the output register; a new access
// can be taken every cycle unless the result side stalls. The RAMs are
// single-port synchronous arrays touched once per access at transfer time,
// and their registered read data is held until the result moves on, so
// stalls on the result side never lose data. Video RAM writes are decoded
// and dropped because that memory is never read back on this bus. Memory
// reads of 0x0000-0x7fff and 0xc000-0xdfff pass in_rom_data through and
// report the ROM select and address with the result.
module arcade_board_bus_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_rom_data,
  input  logic        in_nmi_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_rom_select,
  output logic [13:0] out_rom_address,
  output logic [9:0]  out_control_flags,
  output logic [3:0]  out_channel_number
);
  import abbd_pkg::*;

  logic [15:0] dip_r;
  abbd_key_t   key_r;

  logic [7:0] work_ram [RAM_DEPTH];
  logic [7:0] save_ram [RAM_DEPTH];
  logic [7:0] wram_q_r;
  logic [7:0] sram_q_r;

  logic [9:0] ctrl_r, ctrl_nxt;
  logic [3:0] chan_r, chan_nxt;
  logic       bank_r, bank_nxt;

  logic        s1_v_r;
  abbd_src_t   s1_src_r;
  logic [7:0]  s1_rd_r;
  logic [1:0]  s1_sel_r;
  logic [13:0] s1_raddr_r;
  logic [9:0]  s1_ctrl_r;
  logic [3:0]  s1_chan_r;

  logic        out_v_r;
  logic [7:0]  out_rd_r;
  logic [1:0]  out_sel_r;
  logic [13:0] out_raddr_r;
  logic [9:0]  out_ctrl_r;
  logic [3:0]  out_chan_r;

  logic        accept;
  logic        s1_adv;
  logic        is_wram, is_sram, is_prom;
  logic [RAM_AW-1:0] wram_idx, sram_idx;
  logic        wram_wr, wram_rd, sram_wr, sram_rd, prom_wr;
  logic [7:0]  prom_rd;
  abbd_src_t   src;
  logic [7:0]  rd;
  logic [1:0]  sel;
  logic [13:0] raddr;
  logic [7:0]  s1_data;
  logic [4:0]  port;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid && in_ready;

  assign is_wram  = in_address[15:11] == 5'b10000;
  assign is_sram  = in_address[15:11] == 5'b10001;
  assign is_prom  = in_address[15:13] == 3'b111;
  assign wram_idx = in_address[10:0];
  assign sram_idx = {in_address[10] & bank_r, in_address[9:0]};

  assign wram_rd = accept && in_mode == MODE_MEM_RD && is_wram;
  assign wram_wr = accept && in_mode == MODE_MEM_WR && is_wram;
  assign sram_rd = accept && in_mode == MODE_MEM_RD && is_sram;
  assign sram_wr = accept && in_mode == MODE_MEM_WR && is_sram;
  assign prom_wr = accept && in_mode == MODE_MEM_WR && is_prom;
  assign port    = in_address[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_r <= '0;
      key_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DIP:      dip_r <= cfg_wdata[15:0];
        CFG_KEY_LOW:  key_r.key_low <= cfg_wdata;
        CFG_KEY_HIGH: key_r.key_high <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  abbd_prom u_prom (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (prom_wr),
    .wr_data (in_write_data),
    .key     (key_r),
    .rd_data (prom_rd)
  );

  always_ff @(posedge clk) begin
    if (wram_wr) begin
      work_ram[wram_idx] <= in_write_data;
    end
    if (wram_rd) begin
      wram_q_r <= work_ram[wram_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (sram_wr) begin
      save_ram[sram_idx] <= in_write_data;
    end
    if (sram_rd) begin
      sram_q_r <= save_ram[sram_idx];
    end
  end

  always_comb begin
    src   = SRC_LOGIC;
    rd    = '0;
    sel   = ROM_NONE;
    raddr = '0;
    case (in_mode)
      MODE_MEM_RD: begin
        if (!in_address[15]) begin
          sel   = ROM_BIOS;
          raddr = in_address[13:0];
          rd    = in_rom_data;
        end else if (is_wram) begin
          src = SRC_WRAM;
        end else if (is_sram) begin
          src = SRC_SRAM;
        end else if (in_address[15:13] == 3'b110) begin
          sel   = ROM_INSTR;
          raddr = {1'b0, in_address[12:0]};
          rd    = in_rom_data;
        end else if (is_prom) begin
          rd = prom_rd;
        end
      end
      MODE_IO_RD: begin
        case (in_address[1:0])
          IO_PORT_NMI:      rd = {4'b0, in_nmi_state, 3'b0};
          IO_PORT_DIP_LOW:  rd = dip_r[7:0];
          IO_PORT_DIP_HIGH: rd = dip_r[15:8];
          default:          rd = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl_nxt = ctrl_r;
    chan_nxt = chan_r;
    bank_nxt = bank_r;
    if (in_mode == MODE_IO_WR) begin
      case (port) inside
        [5'd0:5'd6]:   ctrl_nxt[port[3:0]] = in_write_data[0];
        [5'd8:5'd10]:  ctrl_nxt[4'(port - IO_CTRL_HI_BASE)] = in_write_data[0];
        [5'd11:5'd14]: chan_nxt[2'(port - IO_CHAN_BASE)] = in_write_data[0];
        IO_SAVE_BANK:  bank_nxt = in_write_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= CTRL_RESET;
      chan_r <= '0;
      bank_r <= 1'b1;
    end else if (accept) begin
      ctrl_r <= ctrl_nxt;
      chan_r <= chan_nxt;
      bank_r <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src_r   <= src;
      s1_rd_r    <= rd;
      s1_sel_r   <= sel;
      s1_raddr_r <= raddr;
      s1_ctrl_r  <= ctrl_nxt;
      s1_chan_r  <= chan_nxt;
    end
  end

  always_comb begin
    case (s1_src_r)
      SRC_WRAM: s1_data = wram_q_r;
      SRC_SRAM: s1_data = sram_q_r;
      default:  s1_data = s1_rd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rd_r    <= s1_data;
      out_sel_r   <= s1_sel_r;
      out_raddr_r <= s1_raddr_r;
      out_ctrl_r  <= s1_ctrl_r;
      out_chan_r  <= s1_chan_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_read_data      = out_rd_r;
  assign out_rom_select     = out_sel_r;
  assign out_rom_address    = out_raddr_r;
  assign out_control_flags  = out_ctrl_r;
  assign out_channel_number = out_chan_r;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor bus decoder testbench
// Sends directed and random bus accesses over the valid/ready channels while
// both sides idle at random. A scoreboard keeps its own copy of the RAMs,
// latches and key PROM port, predicts each result and checks every transfer
// on the result side against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import abbd_pkg::*;

  localparam logic [15:0] BIOS_LAST     = 16'h7fff;
  localparam logic [15:0] WRAM_FIRST    = 16'h8000;
  localparam logic [15:0] WRAM_LAST     = 16'h87ff;
  localparam logic [15:0] SRAM_LOW_LAST = 16'h8bff;
  localparam logic [15:0] SRAM_LAST     = 16'h8fff;
  localparam logic [15:0] OPEN_LAST     = 16'hbfff;
  localparam logic [15:0] IROM_FIRST    = 16'hc000;
  localparam logic [15:0] IROM_LAST     = 16'hdfff;
  localparam logic [15:0] PROM_BASE     = 16'he000;

  localparam logic [4:0] IO_CTRL_LOW_LAST   = 5'd6;
  localparam logic [4:0] IO_CTRL_HIGH_FIRST = 5'd8;
  localparam logic [4:0] IO_CTRL_HIGH_LAST  = 5'd10;
  localparam logic [4:0] IO_CHAN_LAST       = 5'd14;

  localparam int PHASE_ITEMS = 275;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  rom_data;
    logic        nmi_state;
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  rom_select;
    logic [13:0] rom_address;
    logic [9:0]  control_flags;
    logic [3:0]  channel_number;
  } bus_result_t;

  class decode_scoreboard;
    logic [15:0] dip;
    logic [63:0] key_low;
    logic [7:0]  key_high;
    logic [7:0]  work_ram [RAM_DEPTH];
    logic [7:0]  save_ram [RAM_DEPTH];
    bit          work_written [RAM_DEPTH];
    bit          save_written [RAM_DEPTH];
    logic [9:0]  ctrl;
    logic [3:0]  chan;
    logic        bank;
    logic        test_mode;
    logic        clk_level;
    logic [7:0]  counter;
    bus_result_t expected_results [$];
    int          mismatches;

    function new();
      dip        = '0;
      key_low    = '0;
      key_high   = '0;
      ctrl       = CTRL_RESET;
      chan       = '0;
      bank       = 1'b1;
      test_mode  = 1'b0;
      clk_level  = 1'b0;
      counter    = '0;
      mismatches = 0;
    endfunction

    function void set_config(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_DIP:      dip = val[15:0];
        CFG_KEY_LOW:  key_low = val;
        CFG_KEY_HIGH: key_high = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [10:0] save_index(logic [15:0] a);
      return (a <= SRAM_LOW_LAST) ? {1'b0, a[9:0]} : {bank, a[9:0]};
    endfunction

    function bit reads_unwritten(bus_access_t a);
      if (a.mode != MODE_MEM_RD || a.address <= BIOS_LAST || a.address > SRAM_LAST)
        return 1'b0;
      if (a.address <= WRAM_LAST) return !work_written[a.address[10:0]];
      return !save_written[save_index(a.address)];
    endfunction

    function logic [7:0] prom_read();
      logic [7:0] d;
      logic [7:0] kb;
      logic [4:0] idx;
      d = PROM_IDLE_BITS;
      if (!test_mode || counter < PROM_TEST_LIMIT) begin
        idx = counter[7:3];
        if (idx < 5'd8) kb = key_low[{idx[2:0], 3'b000} +: 8];
        else if (idx == 5'd8) kb = key_high;
        else kb = '0;
        d[3] = ~kb[counter[2:0]];
      end else begin
        d = d | ((counter[1] ? 8'h00 : key_high) ^ PROM_DATA_BIT);
      end
      d[4] = d[4] | ~counter[5];
      return d;
    endfunction

    function void prom_write(logic [7:0] wd);
      test_mode = wd[4];
      if (clk_level && !wd[3]) counter = counter + 8'd1;
      clk_level = wd[3];
      if (!wd[0]) counter = '0;
    endfunction

    function bus_result_t decode_access(bus_access_t a);
      bus_result_t r;
      logic [4:0]  port;
      r = '0;
      case (a.mode)
        MODE_MEM_RD: begin
          if (a.address <= BIOS_LAST) begin
            r.rom_select  = ROM_BIOS;
            r.rom_address = a.address[13:0];
            r.read_data   = a.rom_data;
          end else if (a.address <= WRAM_LAST) begin
            r.read_data = work_ram[a.address[10:0]];
          end else if (a.address <= SRAM_LAST) begin
            r.read_data = save_ram[save_index(a.address)];
          end else if (a.address <= OPEN_LAST) begin
            r.read_data = '0;
          end else if (a.address <= IROM_LAST) begin
            r.rom_select  = ROM_INSTR;
            r.rom_address = {1'b0, a.address[12:0]};
            r.read_data   = a.rom_data;
          end else begin
            r.read_data = prom_read();
          end
        end
        MODE_MEM_WR: begin
          if (a.address > BIOS_LAST && a.address <= WRAM_LAST) begin
            work_ram[a.address[10:0]]     = a.write_data;
            work_written[a.address[10:0]] = 1'b1;
          end else if (a.address > WRAM_LAST && a.address <= SRAM_LAST) begin
            save_ram[save_index(a.address)]     = a.write_data;
            save_written[save_index(a.address)] = 1'b1;
          end else if (a.address >= PROM_BASE) begin
            prom_write(a.write_data);
          end
        end
        MODE_IO_RD: begin
          case (a.address[1:0])
            IO_PORT_NMI:      r.read_data = {4'b0000, a.nmi_state, 3'b000};
            IO_PORT_DIP_LOW:  r.read_data = dip[7:0];
            IO_PORT_DIP_HIGH: r.read_data = dip[15:8];
            default:          r.read_data = '0;
          endcase
        end
        default: begin
          port = a.address[4:0];
          if (port <= IO_CTRL_LOW_LAST)
            ctrl[4'(port)] = a.write_data[0];
          else if (port >= IO_CTRL_HIGH_FIRST && port <= IO_CTRL_HIGH_LAST)
            ctrl[4'(port - IO_CTRL_HI_BASE)] = a.write_data[0];
          else if (port >= IO_CHAN_BASE && port <= IO_CHAN_LAST)
            chan[2'(port - IO_CHAN_BASE)] = a.write_data[0];
          else if (port == IO_SAVE_BANK)
            bank = a.write_data[0];
        end
      endcase
      r.control_flags  = ctrl;
      r.channel_number = chan;
      return r;
    endfunction

    function void note_access(bus_access_t a);
      expected_results.push_back(decode_access(a));
    endfunction

    function void check_result(bus_result_t r);
      bus_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: rd=%h sel=%0d raddr=%h ctrl=%h chan=%h",
                   r.read_data, r.rom_select, r.rom_address, r.control_flags,
                   r.channel_number);
        return;
      end
      e = expected_results.pop_front();
      if (e !== r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected rd=%h sel=%0d raddr=%h ctrl=%h chan=%h",
                   e.read_data, e.rom_select, e.rom_address, e.control_flags,
                   e.channel_number);
          $display("          actual   rd=%h sel=%0d raddr=%h ctrl=%h chan=%h",
                   r.read_data, r.rom_select, r.rom_address, r.control_flags,
                   r.channel_number);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [7:0]  in_rom_data = '0;
  logic        in_nmi_state = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic [1:0]  out_rom_select;
  logic [13:0] out_rom_address;
  logic [9:0]  out_control_flags;
  logic [3:0]  out_channel_number;

  decode_scoreboard sb;
  bus_result_t      seen;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               hold_cycles = 0;
  int               sent_items = 0;

  arcade_board_bus_decoder DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_rom_data        (in_rom_data),
    .in_nmi_state       (in_nmi_state),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_rom_select     (out_rom_select),
    .out_rom_address    (out_rom_address),
    .out_control_flags  (out_control_flags),
    .out_channel_number (out_channel_number)
  );

  always #5 clk = ~clk;

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.read_data      = out_read_data;
      seen.rom_select     = out_rom_select;
      seen.rom_address    = out_rom_address;
      seen.control_flags  = out_control_flags;
      seen.channel_number = out_channel_number;
      sb.check_result(seen);
    end
  end

  function automatic bus_access_t make_access(logic [1:0] mode, logic [15:0] addr,
                                              logic [7:0] wd, logic [7:0] rom,
                                              logic nmi);
    bus_access_t a;
    a.mode       = mode;
    a.address    = addr;
    a.write_data = wd;
    a.rom_data   = rom;
    a.nmi_state  = nmi;
    return a;
  endfunction

  task automatic send_access(bus_access_t a);
    int gap;
    if (sb.reads_unwritten(a)) a.mode = MODE_MEM_WR;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= a.mode;
    in_address    <= a.address;
    in_write_data <= a.write_data;
    in_rom_data   <= a.rom_data;
    in_nmi_state  <= a.nmi_state;
    do @(posedge clk); while (!in_ready);
    sb.note_access(a);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    sb.set_config(idx, val);
  endtask

  task automatic apply_config(logic [15:0] dip, logic [63:0] klow, logic [7:0] khigh);
    write_cfg(CFG_DIP, {48'h0, dip});
    write_cfg(CFG_KEY_LOW, klow);
    write_cfg(CFG_KEY_HIGH, {56'h0, khigh});
  endtask

  // Each step raises and then drops the PROM clock bit with clear held off.
  task automatic prom_walk(bit clear_first, int steps);
    logic        tm;
    logic [15:0] pa;
    logic [7:0]  wd;
    tm = 1'($urandom_range(0, 1));
    if (clear_first) begin
      pa = 16'($urandom);
      pa[15:13] = 3'b111;
      wd = 8'($urandom);
      wd[4] = tm;
      wd[3] = 1'b0;
      wd[0] = 1'b0;
      send_access(make_access(MODE_MEM_WR, pa, wd, 8'($urandom), 1'($urandom)));
    end
    for (int i = 0; i < steps; i++) begin
      pa = 16'($urandom);
      pa[15:13] = 3'b111;
      wd = 8'($urandom);
      wd[4] = tm ^ ($urandom_range(0, 9) == 0);
      wd[3] = 1'b1;
      wd[0] = 1'b1;
      send_access(make_access(MODE_MEM_WR, pa, wd, 8'($urandom), 1'($urandom)));
      wd = 8'($urandom);
      wd[4] = tm ^ ($urandom_range(0, 9) == 0);
      wd[3] = 1'b0;
      wd[0] = 1'b1;
      send_access(make_access(MODE_MEM_WR, pa, wd, 8'($urandom), 1'($urandom)));
      if ($urandom_range(0, 3) == 0)
        send_access(make_access(MODE_MEM_RD, pa, 8'($urandom), 8'($urandom),
                                1'($urandom)));
    end
  endtask

  initial begin
    int          pick;
    logic [15:0] addr;
    logic [7:0]  wd;
    logic [15:0] off;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_config(16'hffff, 64'h0123_4567_89ab_cdef, 8'hff);
    send_access(make_access(MODE_MEM_RD, 16'h0000, 8'h00, 8'hff, 1'b1));
    send_access(make_access(MODE_MEM_RD, IROM_FIRST, 8'hff, 8'ha5, 1'b0));
    send_access(make_access(MODE_MEM_RD, IROM_LAST, 8'h00, 8'h5a, 1'b1));
    send_access(make_access(MODE_MEM_WR, WRAM_FIRST, 8'hff, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_WR, WRAM_LAST, 8'h00, 8'hff, 1'b1));
    send_access(make_access(MODE_MEM_RD, WRAM_FIRST, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_RD, WRAM_LAST, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_WR, 16'h8c00, 8'h3c, 8'h00, 1'b0));
    send_access(make_access(MODE_IO_WR, {11'h0, IO_SAVE_BANK}, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_WR, SRAM_LAST, 8'hc3, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_RD, SRAM_LOW_LAST, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_WR, 16'h9000, 8'h77, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_RD, 16'h97ff, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_WR, 16'hd000, 8'h99, 8'h00, 1'b0));
    send_access(make_access(MODE_IO_RD, 16'h0000, 8'h00, 8'h00, 1'b1));
    send_access(make_access(MODE_IO_RD, 16'hfffd, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_IO_RD, 16'h0002, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_IO_WR, 16'h0007, 8'hff, 8'h00, 1'b0));
    send_access(make_access(MODE_IO_WR, 16'h000a, 8'h01, 8'h00, 1'b0));
    send_access(make_access(MODE_IO_WR, 16'h000e, 8'h01, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_RD, PROM_BASE, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_WR, 16'hffff, 8'h19, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_WR, PROM_BASE, 8'h11, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_RD, PROM_BASE, 8'h00, 8'h00, 1'b0));
    send_access(make_access(MODE_MEM_WR, PROM_BASE, 8'h00, 8'h00, 1'b0));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          apply_config(16'h0000, 64'h0, 8'h00);
        end
        1: begin
          idle_pct = 76;
          stall_pct = 0;
          apply_config(16'($urandom), {$urandom, $urandom}, 8'($urandom));
        end
        2: begin
          idle_pct = 0;
          stall_pct = 76;
          apply_config(16'hffff, 64'hffff_ffff_ffff_ffff, 8'h00);
          hold_cycles = 400;
        end
        default: begin
          idle_pct = 8;
          stall_pct = 8;
          apply_config(16'($urandom), {$urandom, $urandom}, 8'($urandom));
        end
      endcase
      if (phase == 0 || phase == 2) prom_walk(1'b1, $urandom_range(72, 100));
      while (sent_items < 25 + PHASE_ITEMS * (phase + 1)) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          addr = $urandom_range(0, 1) ? 16'($urandom_range(0, BIOS_LAST))
                                      : 16'($urandom_range(IROM_FIRST, IROM_LAST));
          send_access(make_access(MODE_MEM_RD, addr, 8'($urandom), 8'($urandom),
                                  1'($urandom)));
        end else if (pick < 50) begin
          if ($urandom_range(0, 1))
            off = 16'(16'h0400 * $urandom_range(0, 3) + $urandom_range(0, 15));
          else
            off = 16'($urandom_range(0, 16'h17ff));
          send_access(make_access($urandom_range(0, 1) ? MODE_MEM_RD : MODE_MEM_WR,
                                  WRAM_FIRST + off, 8'($urandom), 8'($urandom),
                                  1'($urandom)));
        end else if (pick < 65) begin
          addr = 16'($urandom);
          if ($urandom_range(0, 3) == 0) addr[4:0] = IO_SAVE_BANK;
          send_access(make_access(MODE_IO_WR, addr, 8'($urandom), 8'($urandom),
                                  1'($urandom)));
        end else if (pick < 75) begin
          send_access(make_access(MODE_IO_RD, 16'($urandom), 8'($urandom),
                                  8'($urandom), 1'($urandom)));
        end else if (pick < 79) begin
          prom_walk($urandom_range(0, 4) == 0, $urandom_range(1, 16));
        end else if (pick < 85) begin
          addr = 16'($urandom);
          addr[15:13] = 3'b111;
          send_access(make_access(MODE_MEM_RD, addr, 8'($urandom), 8'($urandom),
                                  1'($urandom)));
        end else begin
          wd = 8'($urandom);
          send_access(make_access(2'($urandom), 16'($urandom), wd, 8'($urandom),
                                  1'($urandom)));
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
